// ----- hdl/prrl_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// prrl_pkg
// Shared types and constants of the pinned ring record log.
// ----------------------------------------------------------------------------
package prrl_pkg;

	// log memory geometry
	localparam int MEM_BYTES = 65536;
	localparam int MEM_AW    = $clog2(MEM_BYTES);
	localparam int READ_MAX  = 64;

	// physical address and capacity width (holds MEM_BYTES itself)
	localparam int PA_W  = 17;
	localparam int OFF_W = 48;
	localparam int CNT_W = 7;

	localparam logic [PA_W-1:0]  MEM_END   = PA_W'(MEM_BYTES);
	localparam logic [PA_W-1:0]  CAP_RESET = 17'h10000;
	localparam logic [CNT_W-1:0] RD_MAX    = CNT_W'(READ_MAX);
	localparam int               HDR_BYTES = 8;

	// request opcodes
	typedef enum logic [1:0] {
		OP_BEGIN  = 2'd0,
		OP_APPEND = 2'd1,
		OP_READ   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	// result status codes
	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_TOO_LONG = 2'd1,
		STAT_CREATE   = 2'd2,
		STAT_SEQ      = 2'd3
	} stat_t;

	// sequencer states
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_END_LOAD,
		ST_MOD,
		ST_EV_CHK,
		ST_EV_ADDR,
		ST_EV_RD,
		ST_EV_WAIT,
		ST_EV_UPD,
		ST_HDR_WR,
		ST_BEGIN_DONE,
		ST_APPEND,
		ST_RD_SETUP,
		ST_RD_CALC,
		ST_RD_CNT,
		ST_RD_ISSUE,
		ST_RD_CAP,
		ST_RESP
	} state_t;

endpackage
`default_nettype wire

// ----- hdl/pinned_ring_record_log_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pinned_ring_record_log_top
// Byte ring log of length-prefixed records with a protected create prefix.
// ----------------------------------------------------------------------------
// Append: dispatch, then the memory write, then the result register.
// Begin: the header is written byte by byte; each evicted record adds a pass of
// the bit-serial modulo unit plus the reads of its header bytes.
// Read: a modulo pass for the start address outside the pinned prefix, then
// each byte is issued and captured through the single memory read port. A remap
// after a config write or a pinned prefix change costs one more modulo pass.
// Reset: control state clears at once; the log memory is not cleared.
// ----------------------------------------------------------------------------
module pinned_ring_record_log_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration
	input  wire logic                          cfg_we,
	input  wire logic [prrl_pkg::PA_W-1:0]     cfg_wdata,
	// request channel
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [1:0]                    op,
	input  wire logic [15:0]                   record_len,
	input  wire logic                          create_record,
	input  wire logic [7:0]                    payload_byte,
	input  wire logic [prrl_pkg::OFF_W-1:0]    read_offset,
	input  wire logic [prrl_pkg::CNT_W-1:0]    read_limit,
	// result channel
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [7:0]                         out_byte,
	output logic                               is_last,
	output logic [prrl_pkg::OFF_W-1:0]         next_offset,
	output logic [prrl_pkg::CNT_W-1:0]         byte_count,
	output logic [1:0]                         status,
	output logic [prrl_pkg::OFF_W-1:0]         lost_count
);

	localparam int PW = prrl_pkg::PA_W;
	localparam int OW = prrl_pkg::OFF_W;
	localparam int CW = prrl_pkg::CNT_W;

	prrl_pkg::state_t state_q, state_d, mod_ret_q;

	// architectural state
	logic [PW-1:0] capacity_q;
	logic [OW-1:0] end_q, begin_q, lost_q;
	logic [PW-1:0] pinned_q, bytes_left_q, open_len_q;
	logic          open_create_q;

	// cached physical address of end_q
	logic [PW-1:0] end_phys_q;
	logic          end_ok_q;

	// request holding
	logic [1:0]    op_q;
	logic [15:0]   len_q;
	logic          cr_q;
	logic [7:0]    pb_q;
	logic [PW-1:0] need_q;
	logic          hdr_phase_q;
	logic [2:0]    hcnt_q;
	logic [1:0]    resp_stat_q;
	logic [OW-1:0] resp_next_q;

	// modulo unit
	logic [OW-1:0] mod_x_q;
	logic [PW-1:0] mod_r_q;
	logic [5:0]    mod_cnt_q;

	// eviction
	logic [PW-1:0] ev_phys_q;
	logic [63:0]   hdr_q;
	logic          ev_pend_s1;

	// read
	logic [OW-1:0] off_q;
	logic [CW-1:0] lim_q, rl_q, left_q, n_q, idx_q;
	logic [PW-1:0] phys_q, rd_addr_q;

	// result register
	logic          out_valid_q, is_last_q;
	logic [7:0]    out_byte_q;
	logic [OW-1:0] next_offset_q, lost_out_q;
	logic [CW-1:0] byte_count_q;
	logic [1:0]    status_q;

	// memory
	logic [7:0]    mem [prrl_pkg::MEM_BYTES];
	logic          mem_we, mem_re;
	logic [PW-1:0] mem_wa, mem_ra;
	logic [7:0]    mem_wd, mem_rd_q;
	logic          rd_oor_s1;
	logic [7:0]    rd_byte;

	// ring geometry
	logic [PW-1:0] cap_eff, ring_len, mod_phys, end_phys_inc, ev_phys_inc;
	logic          out_free;

	assign cap_eff  = (capacity_q > prrl_pkg::MEM_END) ? prrl_pkg::MEM_END : capacity_q;
	assign ring_len = (cap_eff > pinned_q) ? cap_eff - pinned_q : '0;
	assign mod_phys = (ring_len == '0) ? pinned_q : mod_r_q + pinned_q;
	assign out_free = !out_valid_q || out_ready;
	assign rd_byte  = rd_oor_s1 ? 8'd0 : mem_rd_q;

	assign end_phys_inc = (({1'b0, end_phys_q} + 18'd1 >= {1'b0, cap_eff}) || ring_len == '0)
		? pinned_q : end_phys_q + 1'b1;
	assign ev_phys_inc = (({1'b0, ev_phys_q} + 18'd1 >= {1'b0, cap_eff}) || ring_len == '0)
		? pinned_q : ev_phys_q + 1'b1;

	// modulo step: shift one dividend bit in, subtract when it fits
	logic [PW:0] mod_sh, mod_nx;
	assign mod_sh = {mod_r_q, mod_x_q[OW-1]};
	assign mod_nx = (mod_sh >= {1'b0, ring_len}) ? mod_sh - {1'b0, ring_len} : mod_sh;

	// eviction arithmetic
	logic [OW-1:0] used, used_m8, begin_nx;
	logic [PW-1:0] space;
	logic          ev_done, hdr_bad;
	assign used     = end_q - begin_q;
	assign used_m8  = used - OW'(prrl_pkg::HDR_BYTES);
	assign space    = (used >= OW'(ring_len)) ? '0 : ring_len - used[PW-1:0];
	assign ev_done  = (space > need_q) || (used == '0);
	assign hdr_bad  = (used < OW'(prrl_pkg::HDR_BYTES)) || (hdr_q[63:48] != '0) ||
		(hdr_q[47:0] > used_m8);
	assign begin_nx = hdr_bad ? end_q : begin_q + hdr_q[47:0] + OW'(prrl_pkg::HDR_BYTES);

	// begin checks
	logic too_long;
	assign too_long = (ring_len == '0) ||
		({2'b00, record_len} + 18'(prrl_pkg::HDR_BYTES) >= {1'b0, ring_len});

	// read setup at accept
	logic [CW-1:0] lim_in, prefix_rl;
	logic [PW-1:0] pdiff;
	logic [OW-1:0] off_lo, off_c;
	logic          in_prefix;
	assign lim_in    = (read_limit > prrl_pkg::RD_MAX) ? prrl_pkg::RD_MAX : read_limit;
	assign in_prefix = read_offset < OW'(pinned_q);
	assign pdiff     = pinned_q - read_offset[PW-1:0];
	assign prefix_rl = (pdiff > PW'(lim_in)) ? lim_in : pdiff[CW-1:0];
	assign off_lo    = (read_offset < begin_q) ? begin_q : read_offset;
	assign off_c     = (off_lo > end_q) ? end_q : off_lo;

	// read span once the start address is known
	logic [PW-1:0] d_fwd, d_wrap, pe_span;
	logic [CW-1:0] rl_c, lim_rem, left_c;
	logic          wrap_over;
	assign d_fwd     = end_phys_q - mod_phys;
	assign d_wrap    = cap_eff - mod_phys;
	always_comb begin
		if (mod_phys <= end_phys_q) begin
			rl_c = (d_fwd > PW'(lim_q)) ? lim_q : d_fwd[CW-1:0];
		end else begin
			rl_c = (d_wrap > PW'(lim_q)) ? lim_q : d_wrap[CW-1:0];
		end
	end
	assign wrap_over = (mod_phys > end_phys_q) &&
		({1'b0, mod_phys} + 18'(lim_q) > {1'b0, cap_eff});
	assign lim_rem   = lim_q - rl_c;
	assign pe_span   = end_phys_q - pinned_q;
	assign left_c    = !wrap_over ? '0 :
		((pe_span > PW'(lim_rem)) ? lim_rem : pe_span[CW-1:0]);

	// finish of an open record
	logic [PW-1:0] pinned_app, pinned_beg;
	assign pinned_app = pinned_q + PW'(prrl_pkg::HDR_BYTES) + open_len_q;
	assign pinned_beg = pinned_q + PW'(prrl_pkg::HDR_BYTES) + PW'(len_q);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= prrl_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and memory strobes
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		mem_we   = 1'b0;
		mem_wa   = end_phys_q;
		mem_wd   = pb_q;
		mem_re   = 1'b0;
		mem_ra   = rd_addr_q;
		unique case (state_q)
			prrl_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (op == prrl_pkg::OP_BEGIN) begin
						if (bytes_left_q != '0 || (create_record && end_q != OW'(pinned_q))
							|| too_long) begin
							state_d = prrl_pkg::ST_RESP;
						end else begin
							state_d = prrl_pkg::ST_DISPATCH;
						end
					end else if (op == prrl_pkg::OP_APPEND) begin
						state_d = (bytes_left_q == '0) ? prrl_pkg::ST_RESP
							: prrl_pkg::ST_DISPATCH;
					end else if (op == prrl_pkg::OP_READ) begin
						state_d = in_prefix ? prrl_pkg::ST_RD_CNT : prrl_pkg::ST_DISPATCH;
					end else begin
						state_d = prrl_pkg::ST_RESP;
					end
				end
			end
			prrl_pkg::ST_DISPATCH: begin
				if (!end_ok_q) begin
					state_d = prrl_pkg::ST_MOD;
				end else if (op_q == prrl_pkg::OP_BEGIN) begin
					state_d = prrl_pkg::ST_EV_CHK;
				end else if (op_q == prrl_pkg::OP_APPEND) begin
					state_d = prrl_pkg::ST_APPEND;
				end else begin
					state_d = prrl_pkg::ST_RD_SETUP;
				end
			end
			prrl_pkg::ST_END_LOAD: state_d = prrl_pkg::ST_DISPATCH;
			prrl_pkg::ST_MOD: begin
				if (mod_cnt_q == 6'(OW - 1)) state_d = mod_ret_q;
			end
			prrl_pkg::ST_EV_CHK: begin
				if (ev_done) begin
					state_d = hdr_phase_q ? prrl_pkg::ST_HDR_WR : prrl_pkg::ST_BEGIN_DONE;
				end else begin
					state_d = prrl_pkg::ST_MOD;
				end
			end
			prrl_pkg::ST_EV_ADDR: state_d = prrl_pkg::ST_EV_RD;
			prrl_pkg::ST_EV_RD: begin
				mem_re = 1'b1;
				mem_ra = ev_phys_q;
				if (hcnt_q == 3'd7) state_d = prrl_pkg::ST_EV_WAIT;
			end
			prrl_pkg::ST_EV_WAIT: state_d = prrl_pkg::ST_EV_UPD;
			prrl_pkg::ST_EV_UPD:  state_d = prrl_pkg::ST_EV_CHK;
			prrl_pkg::ST_HDR_WR: begin
				mem_we = 1'b1;
				mem_wd = (hcnt_q == 3'd0) ? len_q[7:0] :
					((hcnt_q == 3'd1) ? len_q[15:8] : 8'd0);
				if (hcnt_q == 3'd7) state_d = prrl_pkg::ST_EV_CHK;
			end
			prrl_pkg::ST_BEGIN_DONE: state_d = prrl_pkg::ST_RESP;
			prrl_pkg::ST_APPEND: begin
				mem_we  = 1'b1;
				state_d = prrl_pkg::ST_RESP;
			end
			prrl_pkg::ST_RD_SETUP: begin
				state_d = (ring_len == '0) ? prrl_pkg::ST_RD_CNT : prrl_pkg::ST_MOD;
			end
			prrl_pkg::ST_RD_CALC: state_d = prrl_pkg::ST_RD_CNT;
			prrl_pkg::ST_RD_CNT: begin
				state_d = ((rl_q + left_q) == '0) ? prrl_pkg::ST_RESP : prrl_pkg::ST_RD_ISSUE;
			end
			prrl_pkg::ST_RD_ISSUE: begin
				if (out_free) begin
					mem_re  = 1'b1;
					state_d = prrl_pkg::ST_RD_CAP;
				end
			end
			prrl_pkg::ST_RD_CAP: begin
				state_d = (idx_q + 1'b1 == n_q) ? prrl_pkg::ST_IDLE : prrl_pkg::ST_RD_ISSUE;
			end
			prrl_pkg::ST_RESP: begin
				if (out_free) state_d = prrl_pkg::ST_IDLE;
			end
			default: state_d = prrl_pkg::ST_IDLE;
		endcase
	end

	// log memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we && mem_wa < prrl_pkg::MEM_END) begin
			mem[mem_wa[prrl_pkg::MEM_AW-1:0]] <= mem_wd;
		end
		if (mem_re) begin
			mem_rd_q  <= mem[mem_ra[prrl_pkg::MEM_AW-1:0]];
			rd_oor_s1 <= (mem_ra >= prrl_pkg::MEM_END);
		end
	end

	// header bytes arrive little-endian, shift in from the top
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_pend_s1 <= 1'b0;
		end else begin
			ev_pend_s1 <= (state_q == prrl_pkg::ST_EV_RD);
		end
	end

	always_ff @(posedge clk) begin
		if (ev_pend_s1) hdr_q <= {rd_byte, hdr_q[63:8]};
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= prrl_pkg::CAP_RESET;
		end else if (cfg_we) begin
			capacity_q <= cfg_wdata;
		end
	end

	// datapath and log state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_q         <= '0;
			begin_q       <= '0;
			pinned_q      <= '0;
			lost_q        <= '0;
			bytes_left_q  <= '0;
			open_len_q    <= '0;
			open_create_q <= 1'b0;
			end_ok_q      <= 1'b0;
			end_phys_q    <= '0;
			mod_ret_q     <= prrl_pkg::ST_IDLE;
			mod_cnt_q     <= '0;
			hcnt_q        <= '0;
			idx_q         <= '0;
			hdr_phase_q   <= 1'b0;
			op_q          <= '0;
			resp_stat_q   <= '0;
			resp_next_q   <= '0;
		end else begin
			case (state_q)
				prrl_pkg::ST_IDLE: begin
					if (in_valid) begin
						op_q          <= op;
						len_q         <= record_len;
						cr_q          <= create_record;
						pb_q          <= payload_byte;
						need_q        <= PW'(prrl_pkg::HDR_BYTES);
						hdr_phase_q   <= 1'b1;
						lim_q         <= lim_in;
						resp_next_q   <= '0;
						resp_stat_q   <= prrl_pkg::STAT_OK;
						if (op == prrl_pkg::OP_BEGIN) begin
							if (bytes_left_q != '0) begin
								resp_stat_q <= prrl_pkg::STAT_SEQ;
							end else if (create_record && end_q != OW'(pinned_q)) begin
								resp_stat_q <= prrl_pkg::STAT_CREATE;
							end else if (too_long) begin
								resp_stat_q <= prrl_pkg::STAT_TOO_LONG;
							end
						end else if (op == prrl_pkg::OP_APPEND) begin
							if (bytes_left_q == '0) resp_stat_q <= prrl_pkg::STAT_SEQ;
						end else if (op == prrl_pkg::OP_READ) begin
							if (in_prefix) begin
								off_q  <= read_offset;
								phys_q <= read_offset[PW-1:0];
								rl_q   <= prefix_rl;
								left_q <= '0;
							end else begin
								off_q  <= off_c;
							end
						end else begin
							resp_stat_q <= prrl_pkg::STAT_SEQ;
						end
					end
				end
				prrl_pkg::ST_DISPATCH: begin
					if (!end_ok_q) begin
						mod_x_q   <= end_q - OW'(pinned_q);
						mod_r_q   <= '0;
						mod_cnt_q <= '0;
						mod_ret_q <= prrl_pkg::ST_END_LOAD;
					end
				end
				prrl_pkg::ST_END_LOAD: begin
					end_phys_q <= mod_phys;
					end_ok_q   <= 1'b1;
				end
				prrl_pkg::ST_MOD: begin
					mod_r_q   <= mod_nx[PW-1:0];
					mod_x_q   <= {mod_x_q[OW-2:0], 1'b0};
					mod_cnt_q <= mod_cnt_q + 1'b1;
				end
				prrl_pkg::ST_EV_CHK: begin
					hcnt_q <= '0;
					if (!ev_done) begin
						mod_x_q   <= begin_q - OW'(pinned_q);
						mod_r_q   <= '0;
						mod_cnt_q <= '0;
						mod_ret_q <= prrl_pkg::ST_EV_ADDR;
					end
				end
				prrl_pkg::ST_EV_ADDR: begin
					ev_phys_q <= mod_phys;
					hcnt_q    <= '0;
				end
				prrl_pkg::ST_EV_RD: begin
					ev_phys_q <= ev_phys_inc;
					hcnt_q    <= hcnt_q + 1'b1;
				end
				prrl_pkg::ST_EV_UPD: begin
					begin_q <= begin_nx;
					lost_q  <= lost_q + 1'b1;
				end
				prrl_pkg::ST_HDR_WR: begin
					end_q      <= end_q + 1'b1;
					end_phys_q <= end_phys_inc;
					hcnt_q     <= hcnt_q + 1'b1;
					if (hcnt_q == 3'd7) begin
						need_q      <= PW'(len_q);
						hdr_phase_q <= 1'b0;
					end
				end
				prrl_pkg::ST_BEGIN_DONE: begin
					open_len_q    <= PW'(len_q);
					bytes_left_q  <= PW'(len_q);
					open_create_q <= cr_q && (len_q != '0);
					// empty record closes at once
					if (len_q == '0 && cr_q) begin
						pinned_q <= pinned_beg;
						begin_q  <= OW'(pinned_beg);
						end_ok_q <= 1'b0;
					end
				end
				prrl_pkg::ST_APPEND: begin
					end_q        <= end_q + 1'b1;
					end_phys_q   <= end_phys_inc;
					bytes_left_q <= bytes_left_q - 1'b1;
					// last payload byte closes the record
					if (bytes_left_q == PW'(1)) begin
						open_create_q <= 1'b0;
						if (open_create_q) begin
							pinned_q <= pinned_app;
							begin_q  <= OW'(pinned_app);
							end_ok_q <= 1'b0;
						end
					end
				end
				prrl_pkg::ST_RD_SETUP: begin
					if (ring_len == '0) begin
						rl_q   <= '0;
						left_q <= '0;
					end else begin
						mod_x_q   <= off_q - OW'(pinned_q);
						mod_r_q   <= '0;
						mod_cnt_q <= '0;
						mod_ret_q <= prrl_pkg::ST_RD_CALC;
					end
				end
				prrl_pkg::ST_RD_CALC: begin
					phys_q <= mod_phys;
					rl_q   <= rl_c;
					left_q <= left_c;
				end
				prrl_pkg::ST_RD_CNT: begin
					n_q         <= rl_q + left_q;
					resp_next_q <= off_q + OW'(rl_q + left_q);
					idx_q       <= '0;
					rd_addr_q   <= (rl_q == '0) ? pinned_q : phys_q;
				end
				prrl_pkg::ST_RD_ISSUE: begin
					if (out_free) begin
						rd_addr_q <= (idx_q + 1'b1 == rl_q) ? pinned_q : rd_addr_q + 1'b1;
					end
				end
				prrl_pkg::ST_RD_CAP: begin
					idx_q <= idx_q + 1'b1;
				end
				default: ;
			endcase
			// new capacity changes the address map
			if (cfg_we) end_ok_q <= 1'b0;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == prrl_pkg::ST_RD_CAP ||
			(state_q == prrl_pkg::ST_RESP && out_free)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == prrl_pkg::ST_RD_CAP) begin
			out_byte_q    <= rd_byte;
			is_last_q     <= (idx_q + 1'b1 == n_q);
			next_offset_q <= resp_next_q;
			byte_count_q  <= n_q;
			status_q      <= prrl_pkg::STAT_OK;
			lost_out_q    <= lost_q;
		end else if (state_q == prrl_pkg::ST_RESP && out_free) begin
			out_byte_q    <= 8'd0;
			is_last_q     <= 1'b1;
			next_offset_q <= resp_next_q;
			byte_count_q  <= '0;
			status_q      <= resp_stat_q;
			lost_out_q    <= lost_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign is_last     = is_last_q;
	assign next_offset = next_offset_q;
	assign byte_count  = byte_count_q;
	assign status      = status_q;
	assign lost_count  = lost_out_q;

`ifndef SYNTHESIS
	// a byte capture must never overwrite a pending result
	a_cap_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == prrl_pkg::ST_RD_CAP |-> !out_valid_q)
		else $error("read capture while result pending");

	// an open create record always has payload left
	a_create_open: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == prrl_pkg::ST_IDLE && open_create_q) |-> bytes_left_q != '0)
		else $error("create record open with no bytes left");

	// cached end address does not fall below the pinned prefix
	a_end_phys: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == prrl_pkg::ST_IDLE && end_ok_q) |-> end_phys_q >= pinned_q)
		else $error("end address below pinned prefix");

	// each eviction counts exactly one lost record
	a_lost_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == prrl_pkg::ST_EV_UPD |=> lost_q == $past(lost_q) + 1'b1)
		else $error("lost counter step");
`endif

endmodule
`default_nettype wire

// ----- tb/tb_pinned_ring_record_log_top.sv -----
// ----------------------------------------------------------------------------
// tb_pinned_ring_record_log_top
// Self-checking bench for the pinned ring record log. A scoreboard class keeps
// its own copy of the log state and predicts every result. Stimulus covers
// directed corner requests, a full pass over the log memory, and random
// record, read and noise traffic under several capacity settings. Both
// channels see random idle bursts.
// ----------------------------------------------------------------------------
module tb_pinned_ring_record_log_top;
	import prrl_pkg::*;

	localparam longint unsigned M48 = 64'hFFFF_FFFF_FFFF;
	localparam int CYCLE_LIMIT = 3000000;

	typedef struct {
		op_t         op;
		logic [15:0] len;
		logic        cr;
		logic [7:0]  pb;
		logic [47:0] off;
		logic [6:0]  lim;
	} req_t;

	typedef struct {
		logic [7:0]  data;
		logic        last;
		logic [47:0] nxt;
		logic [6:0]  cnt;
		logic [1:0]  st;
		logic [47:0] lost;
	} rsp_t;

	// log state mirror and queue of pending results
	class log_scoreboard;
		bit [7:0] mem [MEM_BYTES];
		longint unsigned cap, endo, bego, pinned, lost, left, olen;
		bit ocr;
		rsp_t pending [$];
		int errors;

		function new();
			cap = 65536; endo = 0; bego = 0; pinned = 0;
			lost = 0; left = 0; olen = 0; ocr = 0; errors = 0;
		endfunction

		function longint unsigned ring_len();
			longint unsigned c;
			c = (cap > MEM_BYTES) ? MEM_BYTES : cap;
			return (c > pinned) ? c - pinned : 0;
		endfunction

		function longint unsigned phys(longint unsigned lo);
			longint unsigned pl;
			pl = ring_len();
			if (pl == 0) return pinned;
			return ((lo - pinned) & M48) % pl + pinned;
		endfunction

		function bit [7:0] rd(longint unsigned a);
			return (a < MEM_BYTES) ? mem[a] : 8'd0;
		endfunction

		function void wr(longint unsigned a, bit [7:0] v);
			if (a < MEM_BYTES) mem[a] = v;
		endfunction

		// drop oldest records until the free space exceeds need
		function void evict(longint unsigned need);
			longint unsigned pl, used, space, hdr;
			pl = ring_len();
			forever begin
				used = (endo - bego) & M48;
				space = (used >= pl) ? 0 : pl - used;
				if (space > need || used == 0) return;
				hdr = 0;
				for (int i = 7; i >= 0; i--)
					hdr = (hdr << 8) | rd(phys((bego + i) & M48));
				if (used < 8 || hdr > used - 8)
					bego = endo;
				else
					bego = (bego + hdr + 8) & M48;
				lost = (lost + 1) & M48;
			end
		endfunction

		function void close_record();
			if (ocr) begin
				pinned = (pinned + 8 + olen) & 64'h1FFFF;
				bego = pinned;
			end
			ocr = 0;
		endfunction

		function void push(longint unsigned b, bit last, longint unsigned nxt,
				longint unsigned cnt, stat_t st);
			rsp_t r;
			r.data = b[7:0]; r.last = last; r.nxt = nxt[47:0];
			r.cnt = cnt[6:0]; r.st = st; r.lost = lost[47:0];
			pending.push_back(r);
		endfunction

		function void predict_read(longint unsigned off, longint unsigned lim);
			longint unsigned ph, rl, lft, n, pe, c;
			rl = 0; lft = 0; ph = 0;
			c = (cap > MEM_BYTES) ? MEM_BYTES : cap;
			if (lim > READ_MAX) lim = READ_MAX;
			if (off < pinned) begin
				ph = off;
				rl = pinned - off;
				if (rl > lim) rl = lim;
			end else begin
				if (off < bego) off = bego;
				if (off > endo) off = endo;
				ph = phys(off);
				pe = phys(endo);
				if (ring_len() == 0) begin
					rl = 0;
				end else if (ph <= pe) begin
					rl = pe - ph;
					if (rl > lim) rl = lim;
				end else begin
					rl = c - ph;
					if (rl > lim) rl = lim;
					if (ph + lim > c) begin
						lft = lim - rl;
						if (lft > pe - pinned) lft = pe - pinned;
					end
				end
			end
			n = rl + lft;
			off = (off + n) & M48;
			if (n == 0) begin
				push(0, 1, off, 0, STAT_OK);
				return;
			end
			for (longint unsigned i = 0; i < n; i++)
				push(rd(i < rl ? ph + i : pinned + (i - rl)), i + 1 == n, off, n, STAT_OK);
		endfunction

		// note an accepted request and queue what it must produce
		function void note(req_t q);
			stat_t st;
			longint unsigned pl, len;
			st = STAT_OK;
			len = q.len;
			case (q.op)
				OP_READ: begin
					predict_read(q.off, q.lim);
					return;
				end
				OP_BEGIN: begin
					pl = ring_len();
					if (left != 0) st = STAT_SEQ;
					else if (q.cr && endo != pinned) st = STAT_CREATE;
					else if (pl == 0 || 8 + len >= pl) st = STAT_TOO_LONG;
					else begin
						evict(8);
						for (int i = 0; i < 8; i++)
							wr(phys((endo + i) & M48), 8'((len >> (8 * i)) & 8'hFF));
						endo = (endo + 8) & M48;
						evict(len);
						olen = len;
						ocr = q.cr;
						left = len;
						if (len == 0) close_record();
					end
				end
				OP_APPEND: begin
					if (left == 0) st = STAT_SEQ;
					else begin
						wr(phys(endo), q.pb);
						endo = (endo + 1) & M48;
						left--;
						if (left == 0) close_record();
					end
				end
				default: st = STAT_SEQ;
			endcase
			push(0, 1, 0, 0, st);
		endfunction

		function void check(rsp_t a);
			rsp_t e;
			if (pending.size() == 0) begin
				$error("result with none expected: byte %0h", a.data);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a.data !== e.data) begin
				$error("out_byte expected %0h got %0h", e.data, a.data); errors++;
			end
			if (a.last !== e.last) begin
				$error("is_last expected %0h got %0h", e.last, a.last); errors++;
			end
			if (a.nxt !== e.nxt) begin
				$error("next_offset expected %0h got %0h", e.nxt, a.nxt); errors++;
			end
			if (a.cnt !== e.cnt) begin
				$error("byte_count expected %0d got %0d", e.cnt, a.cnt); errors++;
			end
			if (a.st !== e.st) begin
				$error("status expected %0d got %0d", e.st, a.st); errors++;
			end
			if (a.lost !== e.lost) begin
				$error("lost_count expected %0h got %0h", e.lost, a.lost); errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [PA_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] op = '0;
	logic [15:0] record_len = '0;
	logic create_record = 1'b0;
	logic [7:0] payload_byte = '0;
	logic [OFF_W-1:0] read_offset = '0;
	logic [CNT_W-1:0] read_limit = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] out_byte;
	logic is_last;
	logic [OFF_W-1:0] next_offset;
	logic [CNT_W-1:0] byte_count;
	logic [1:0] status;
	logic [OFF_W-1:0] lost_count;

	log_scoreboard sb = new();
	bit calm = 1'b1;
	int cycles = 0;
	int rdy_left = 0;

	pinned_ring_record_log_top DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .record_len(record_len), .create_record(create_record),
		.payload_byte(payload_byte), .read_offset(read_offset), .read_limit(read_limit),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_byte(out_byte), .is_last(is_last), .next_offset(next_offset),
		.byte_count(byte_count), .status(status), .lost_count(lost_count)
	);

	always #1 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// result side: random stall bursts unless calm
	always @(posedge clk) begin
		if (calm) begin
			out_ready <= 1'b1;
		end else if (rdy_left == 0) begin
			rdy_left = $urandom_range(1, 10);
			out_ready <= ($urandom_range(0, 2) != 0);
		end else begin
			rdy_left--;
		end
	end

	// result monitor
	always @(posedge clk) begin
		rsp_t r;
		if (arst_n && out_valid && out_ready) begin
			r.data = out_byte; r.last = is_last; r.nxt = next_offset;
			r.cnt = byte_count; r.st = status; r.lost = lost_count;
			sb.check(r);
		end
	end

	// one request through the handshake, with an optional idle gap first
	task automatic send(req_t q);
		int gap;
		gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= q.op;
		record_len <= q.len;
		create_record <= q.cr;
		payload_byte <= q.pb;
		read_offset <= q.off;
		read_limit <= q.lim;
		do @(posedge clk); while (!in_ready);
		sb.note(q);
	endtask

	// request with random don't-care fields
	function automatic req_t mk(op_t o);
		req_t q;
		q.op = o;
		q.len = $urandom;
		q.cr = $urandom_range(0, 1);
		q.pb = $urandom;
		q.off = {16'($urandom), 32'($urandom)};
		q.lim = $urandom_range(0, READ_MAX);
		return q;
	endfunction

	task automatic do_begin(int len, bit cr);
		req_t q;
		q = mk(OP_BEGIN);
		q.len = len;
		q.cr = cr;
		send(q);
	endtask

	task automatic do_append(int n);
		for (int i = 0; i < n; i++) send(mk(OP_APPEND));
	endtask

	task automatic do_read(longint unsigned off, int lim);
		req_t q;
		q = mk(OP_READ);
		q.off = off[47:0];
		q.lim = lim;
		send(q);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	// capacity change only while the block is idle
	task automatic set_capacity(int v);
		drain();
		repeat (300) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.cap = v;
	endtask

	// random traffic: mostly records, mixed with reads and noise
	task automatic random_phase(int n);
		int cnt, k, len;
		req_t q;
		cnt = 0;
		while (cnt < n) begin
			k = $urandom_range(0, 99);
			if (k < 60) begin
				if ($urandom_range(0, 15) == 0) len = $urandom;
				else len = $urandom_range(0, 24);
				do_begin(len, $urandom_range(0, 15) == 0);
				cnt++;
				if (len <= 24) begin
					for (int i = 0; i < len; i++) begin
						if ($urandom_range(0, 40) == 0) begin
							do_begin($urandom_range(0, 24), 0);
							cnt++;
						end
						if ($urandom_range(0, 60) == 0) break;
						do_append(1);
						cnt++;
					end
				end
			end else if (k < 85) begin
				case ($urandom_range(0, 3))
					0: do_read($urandom_range(0, 31), $urandom_range(0, READ_MAX));
					1: do_read(sb.bego + $urandom_range(0, 80) - 8, $urandom_range(0, READ_MAX));
					2: do_read(sb.endo - $urandom_range(0, 70), $urandom_range(0, READ_MAX));
					default: begin
						q = mk(OP_READ);
						send(q);
					end
				endcase
				cnt++;
			end else begin
				case ($urandom_range(0, 2))
					0: send(mk(OP_NONE));
					1: send(mk(OP_APPEND));
					default: do_begin($urandom_range(0, 10), 1);
				endcase
				cnt++;
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners
		calm = 1'b0;
		do_read(0, 10);                 // empty log
		send(mk(OP_APPEND));            // append with nothing open
		send(mk(OP_NONE));              // unused opcode
		do_begin(5, 1);                 // first create record
		send('{OP_APPEND, 16'hFFFF, 1'b1, 8'h00, '1, 7'h7F});
		send('{OP_APPEND, 16'h0000, 1'b0, 8'hFF, '0, 7'h00});
		do_append(3);
		do_begin(0, 1);                 // empty create extends the prefix
		do_begin(16'hFFFF, 0);          // too long
		do_read(0, READ_MAX);           // protected prefix
		do_begin(3, 0);
		do_begin(2, 0);                 // begin while open
		do_append(3);
		do_begin(1, 1);                 // create after ring data
		do_read(21, READ_MAX);
		do_read(M48, READ_MAX);         // beyond end, clamped

		// one maximal record writes every log byte, so later reads and
		// eviction walks never touch unwritten memory
		calm = 1'b1;
		drain();
		do_begin(sb.ring_len() - 9, 0);
		do_append(sb.ring_len() - 9);
		do_read(sb.bego, READ_MAX);     // oldest data; the ring end has wrapped
		drain();

		// random traffic over several capacities
		calm = 1'b0;
		set_capacity(64);
		random_phase(70);
		set_capacity(65536);
		random_phase(70);
		set_capacity($urandom_range(64, 65535));
		random_phase(60);
		set_capacity(65535);
		calm = 1'b1;
		random_phase(70);

		drain();
		repeat (300) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/prrl_pkg.sv
hdl/pinned_ring_record_log_top.sv
tb/tb_pinned_ring_record_log_top.sv
